// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, switched off while reset is held.
`define EIDM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assertion that a condition at one edge implies a consequence at the same edge.
`define EIDM_ASSERT_IMPL(lbl, cond, cons, msg) \
	`EIDM_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

// ===== sv/eidm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package eidm_pkg;

	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_ATTACH = 3'd2;
	localparam logic [2:0] REQ_DETACH = 3'd3;
	localparam logic [2:0] REQ_QUERY  = 3'd4;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_REJ  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] entity_id;
		logic       id_ok;
		logic [4:0] component_index;
		logic       comp_ok;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  new_entity_id;
		logic        entity_exists;
		logic        has_component;
		logic [31:0] component_mask;
		logic [7:0]  live_count;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/entity_id_allocator_component_map_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Entity identifier allocator with a component bitmask per entity. Each request word is
// taken into a two-word queue and then executed in a read step, which reads the mask memory
// at the addressed entry and the top of the free stack, and an update step, which updates the
// tables and loads the result register; a new word leaves the queue only after the last one
// is through and while the result register is free or being taken. When nothing stalls, a
// request word passes through the queue, the read registers and the result register. The queue
// accepts up to two words while a result waits on the output. Masks and the free stack hold
// no reset value and need no clearing pass; the live flags clear at once on reset.
module entity_id_allocator_component_map_core #(
	parameter int ENTITY_SLOTS    = 256,
	parameter int COMPONENT_TYPES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // entity_id, component_index, zero fill
	input  wire logic [2:0]  s_axis_tuser,   // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // new_entity_id, entity_exists,
	                                         // has_component, component_mask,
	                                         // live_count, zero fill
	output logic [1:0]       m_axis_tuser    // status
);

	logic              q_valid;
	eidm_pkg::item_t   q_item;
	logic              q_pop;
	eidm_pkg::result_t res;

	eidm_front #(
		.ENTITY_SLOTS    (ENTITY_SLOTS),
		.COMPONENT_TYPES (COMPONENT_TYPES)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (s_axis_tvalid),
		.in_ready           (s_axis_tready),
		.in_req_type        (s_axis_tuser),
		.in_entity_id       (s_axis_tdata[7:0]),
		.in_component_index (s_axis_tdata[12:8]),
		.q_valid            (q_valid),
		.q_item             (q_item),
		.q_pop              (q_pop)
	);

	eidm_back #(
		.ENTITY_SLOTS    (ENTITY_SLOTS),
		.COMPONENT_TYPES (COMPONENT_TYPES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (m_axis_tvalid),
		.res       (res),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tdata = {6'd0, res.live_count, res.component_mask, res.has_component,
		res.entity_exists, res.new_entity_id};
	assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

// ===== sv/eidm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eidm_front #(
	parameter int ENTITY_SLOTS    = 256,
	parameter int COMPONENT_TYPES = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [2:0]     in_req_type,
	input  wire logic [7:0]     in_entity_id,
	input  wire logic [4:0]     in_component_index,
	output logic                q_valid,
	output eidm_pkg::item_t     q_item,
	input  wire logic           q_pop
);

	eidm_pkg::item_t                   entry_q [eidm_pkg::QDEPTH];
	logic [eidm_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [eidm_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [eidm_pkg::QCNT_W-1:0]       cnt_q;
	eidm_pkg::item_t                   cls;
	logic                              push;
	logic                              pop;

	always_comb begin
		cls.req_type        = in_req_type;
		cls.entity_id       = in_entity_id;
		cls.id_ok           = (in_entity_id != 8'd0) && (32'(in_entity_id) < ENTITY_SLOTS);
		cls.component_index = in_component_index;
		cls.comp_ok         = 32'(in_component_index) < COMPONENT_TYPES;
	end

	assign in_ready = cnt_q != eidm_pkg::QCNT_W'(eidm_pkg::QDEPTH);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_valid  = cnt_q != '0;
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + eidm_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + eidm_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + eidm_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - eidm_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/eidm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eidm_back #(
	parameter int ENTITY_SLOTS    = 256,
	parameter int COMPONENT_TYPES = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire eidm_pkg::item_t q_item,
	output logic                 q_pop,
	output logic                 res_valid,
	output eidm_pkg::result_t    res,
	input  wire logic            res_ready
);

	localparam int SLOTS_USED = (ENTITY_SLOTS < 256) ? ENTITY_SLOTS : 256;
	localparam int MASK_W     = (COMPONENT_TYPES < 32) ? COMPONENT_TYPES : 32;
	localparam int TOP_ID     = (ENTITY_SLOTS - 1 < 255) ? ENTITY_SLOTS - 1 : 255;
	localparam int LIVE_AW    = $clog2(SLOTS_USED);
	localparam int CNT_W      = $clog2(SLOTS_USED + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                  st_q;
	logic [SLOTS_USED-1:0] live_q;
	logic [CNT_W-1:0]      stk_cnt_q;
	logic [7:0]            fresh_q;
	logic [7:0]            total_q;

	logic [MASK_W-1:0]     mask_mem [SLOTS_USED];
	logic [7:0]            stack_mem [SLOTS_USED];

	eidm_pkg::item_t       it_s1;
	logic [MASK_W-1:0]     mask_rd_s1;
	logic [7:0]            stack_rd_s1;

	logic                  out_valid_q;
	eidm_pkg::result_t     out_q;

	logic [LIVE_AW-1:0]    idx;
	logic [LIVE_AW-1:0]    got_idx;
	logic [LIVE_AW-1:0]    live_wa;
	logic [MASK_W-1:0]     bitv;
	logic                  live;
	logic                  from_stack;
	logic                  fresh_ok;
	logic [7:0]            got;
	logic                  mask_we;
	logic [LIVE_AW-1:0]    mask_wa;
	logic [MASK_W-1:0]     mask_wd;
	logic                  live_set;
	logic                  live_clr;
	logic                  push;
	logic                  stk_pop;
	logic                  fresh_inc;
	logic                  tot_inc;
	logic                  tot_dec;
	logic [1:0]            status;
	logic [7:0]            new_id;
	logic                  live_after;
	logic [MASK_W-1:0]     mask_after;
	logic [MASK_W-1:0]     mask_rep;
	logic                  exec;

	assign q_pop     = (st_q == ST_IDLE) && q_valid && (!out_valid_q || res_ready);
	assign exec      = st_q == ST_EXEC;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		idx        = it_s1.entity_id[LIVE_AW-1:0];
		bitv       = it_s1.comp_ok ? (MASK_W'(1) << it_s1.component_index) : '0;
		live       = it_s1.id_ok && live_q[idx];
		from_stack = stk_cnt_q != '0;
		fresh_ok   = fresh_q < 8'(TOP_ID);
		got        = from_stack ? stack_rd_s1 : (fresh_ok ? fresh_q + 8'd1 : 8'd0);
		got_idx    = got[LIVE_AW-1:0];
		mask_we    = 1'b0;
		mask_wa    = idx;
		mask_wd    = mask_rd_s1;
		live_set   = 1'b0;
		live_clr   = 1'b0;
		live_wa    = idx;
		push       = 1'b0;
		stk_pop    = 1'b0;
		fresh_inc  = 1'b0;
		tot_inc    = 1'b0;
		tot_dec    = 1'b0;
		status     = eidm_pkg::STATUS_REJ;
		new_id     = 8'd0;
		live_after = live;
		mask_after = mask_rd_s1;
		case (it_s1.req_type)
			eidm_pkg::REQ_CREATE: begin
				stk_pop   = from_stack;
				fresh_inc = !from_stack && fresh_ok;
				if (got != 8'd0) begin
					live_set   = 1'b1;
					live_wa    = got_idx;
					mask_we    = 1'b1;
					mask_wa    = got_idx;
					mask_wd    = '0;
					tot_inc    = !live_q[got_idx];
					status     = eidm_pkg::STATUS_OK;
					new_id     = got;
					live_after = 1'b1;
					mask_after = '0;
				end else begin
					status     = eidm_pkg::STATUS_FULL;
					live_after = 1'b0;
				end
			end
			eidm_pkg::REQ_REMOVE: begin
				if (live) begin
					live_clr   = 1'b1;
					push       = 1'b1;
					tot_dec    = 1'b1;
					status     = eidm_pkg::STATUS_OK;
					live_after = 1'b0;
				end
			end
			eidm_pkg::REQ_ATTACH: begin
				if (live && (bitv != '0) && ((mask_rd_s1 & bitv) == '0)) begin
					mask_we    = 1'b1;
					mask_wd    = mask_rd_s1 | bitv;
					mask_after = mask_rd_s1 | bitv;
					status     = eidm_pkg::STATUS_OK;
				end
			end
			eidm_pkg::REQ_DETACH: begin
				if (live && (bitv != '0) && ((mask_rd_s1 & bitv) != '0)) begin
					mask_we    = 1'b1;
					mask_wd    = mask_rd_s1 & ~bitv;
					mask_after = mask_rd_s1 & ~bitv;
					status     = eidm_pkg::STATUS_OK;
				end
			end
			eidm_pkg::REQ_QUERY: begin
				if (live && ((mask_rd_s1 & bitv) != '0)) begin
					status = eidm_pkg::STATUS_OK;
				end
			end
			default: begin
				status = eidm_pkg::STATUS_REJ;
			end
		endcase
		mask_rep = live_after ? mask_after : '0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_s1       <= q_item;
			mask_rd_s1  <= mask_mem[q_item.entity_id[LIVE_AW-1:0]];
			stack_rd_s1 <= stack_mem[LIVE_AW'(stk_cnt_q - CNT_W'(1))];
		end
		if (exec && mask_we) begin
			mask_mem[mask_wa] <= mask_wd;
		end
		if (exec && push && (stk_cnt_q < CNT_W'(SLOTS_USED))) begin
			stack_mem[LIVE_AW'(stk_cnt_q)] <= it_s1.entity_id;
		end
		if (exec) begin
			out_q.status         <= status;
			out_q.new_entity_id  <= new_id;
			out_q.entity_exists  <= live_after;
			out_q.has_component  <= (mask_rep & bitv) != '0;
			out_q.component_mask <= 32'(mask_rep);
			out_q.live_count     <= total_q + 8'(tot_inc) - 8'(tot_dec);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			live_q      <= '0;
			stk_cnt_q   <= '0;
			fresh_q     <= 8'd0;
			total_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (exec) begin
				if (live_set) begin
					live_q[live_wa] <= 1'b1;
				end
				if (live_clr) begin
					live_q[live_wa] <= 1'b0;
				end
				if (stk_pop) begin
					stk_cnt_q <= stk_cnt_q - CNT_W'(1);
				end else if (push && (stk_cnt_q < CNT_W'(SLOTS_USED))) begin
					stk_cnt_q <= stk_cnt_q + CNT_W'(1);
				end
				if (fresh_inc) begin
					fresh_q <= fresh_q + 8'd1;
				end
				total_q <= total_q + 8'(tot_inc) - 8'(tot_dec);
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/eidm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module eidm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [55:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// A stalled result word stays put until it is taken.
	`EIDM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

	// A full allocator reports no identifier and no entity.
	`EIDM_ASSERT_IMPL(a_full_empty, m_axis_tvalid && (m_axis_tuser == eidm_pkg::STATUS_FULL), m_axis_tdata[41:0] == 42'd0, "full result carries entity data")

	// An absent entity never shows a component.
	`EIDM_ASSERT_IMPL(a_absent_clear, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[41:9] == 33'd0, "absent entity reports components")

	// A handed-out identifier belongs to a fresh, live, empty entity.
	`EIDM_ASSERT_IMPL(a_new_id_live, m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0), (m_axis_tuser == eidm_pkg::STATUS_OK) && m_axis_tdata[8] && (m_axis_tdata[41:9] == 33'd0), "new identifier without a fresh live entity")

endmodule

bind entity_id_allocator_component_map_core eidm_checker u_eidm_checker (.*);

`default_nettype wire
